/* hw/rtl/mwmf_pkg.sv */
`timescale 1ns / 1ps

package mwmf_pkg;

	localparam int DATA_W     = 16;
	localparam int WINDOW_DEF = 10;

	typedef struct packed {
		logic wr;
		logic scan;
		logic load;
	} ctrl_cmd_t;

endpackage

/* hw/rtl/mwmf_ctrl.sv */
`timescale 1ns / 1ps

module mwmf_ctrl #(
	parameter int WINDOW = mwmf_pkg::WINDOW_DEF,
	parameter int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mwmf_pkg::ctrl_cmd_t    cmd,
	output logic [IDX_W-1:0]       scan_idx
);
	import mwmf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign scan_idx  = idx_q;
	assign cmd.wr    = in_valid && in_ready;
	assign cmd.scan  = (state_q == ST_SCAN);
	assign cmd.load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.wr) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (cmd.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/mwmf_dp.sv */
`timescale 1ns / 1ps

module mwmf_dp #(
	parameter int WINDOW = mwmf_pkg::WINDOW_DEF,
	parameter int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mwmf_pkg::ctrl_cmd_t                 cmd,
	input  logic [IDX_W-1:0]                    scan_idx,
	input  logic signed [mwmf_pkg::DATA_W-1:0]  sample,
	output logic signed [mwmf_pkg::DATA_W-1:0]  median
);
	import mwmf_pkg::*;

	localparam int RANK_W  = $clog2(WINDOW + 1);
	localparam int RANK_HI = WINDOW / 2;
	localparam int RANK_LO = (WINDOW / 2 == 0) ? 0 : WINDOW / 2 - 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	logic signed [DATA_W-1:0] store_q [WINDOW];
	logic [IDX_W-1:0]         wptr_q;
	logic signed [DATA_W-1:0] cand;
	logic [WINDOW-1:0]        lt;
	logic [WINDOW-1:0]        lt_s1;
	logic signed [DATA_W-1:0] cand_s1;
	logic                     valid_s1;
	logic [RANK_W-1:0]        rank;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] hi_q;
	logic signed [DATA_W:0]   pair_sum;
	logic signed [DATA_W-1:0] med_next;
	logic signed [DATA_W-1:0] median_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				store_q[k] <= '0;
			end
			wptr_q <= '0;
		end else if (cmd.wr) begin
			store_q[wptr_q] <= sample;
			wptr_q          <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
		end
	end

	// duplicates ranked by position so ranks form a permutation
	assign cand = store_q[scan_idx];
	always_comb begin
		for (int j = 0; j < WINDOW; j++) begin
			lt[j] = (store_q[j] < cand) || ((store_q[j] == cand) && (IDX_W'(j) < scan_idx));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		lt_s1   <= lt;
		cand_s1 <= cand;
	end

	always_comb begin
		rank = '0;
		for (int j = 0; j < WINDOW; j++) begin
			rank = rank + RANK_W'(lt_s1[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && (rank == RANK_W'(RANK_LO))) begin
			lo_q <= cand_s1;
		end
		if (valid_s1 && (rank == RANK_W'(RANK_HI))) begin
			hi_q <= cand_s1;
		end
	end

	assign pair_sum = (DATA_W + 1)'(lo_q) + (DATA_W + 1)'(hi_q);
	assign med_next = ((WINDOW % 2) == 0) ? DATA_W'(pair_sum >>> 1) : hi_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			median_q <= med_next;
		end
	end

	assign median = median_q;

endmodule

/* hw/rtl/moving_window_median_filter_unit.sv */
`timescale 1ns / 1ps
// The result becomes valid after the ranking scan, the flush state and the load into the output register.
// A new sample is taken only once the previous result has been loaded; the ranking scan visits one ring entry
//   per cycle, comparing it against all entries and counting its rank.
// The next sample is taken while a finished result still waits in the output register.
// Reset (arst_n low, asynchronous): ring cleared to zero, write pointer zero, no result.

module moving_window_median_filter_unit #(
	parameter int WINDOW = mwmf_pkg::WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mwmf_pkg::DATA_W-1:0]        s_tdata,  // [15:0] sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mwmf_pkg::DATA_W-1:0]        m_tdata   // [15:0] median
);
	import mwmf_pkg::*;

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	ctrl_cmd_t                cmd;
	logic [IDX_W-1:0]         scan_idx;
	logic signed [DATA_W-1:0] median;

	mwmf_ctrl #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.scan_idx  (scan_idx)
	);

	mwmf_dp #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.scan_idx (scan_idx),
		.sample   (signed'(s_tdata)),
		.median   (median)
	);

	assign m_tdata = unsigned'(median);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a sample is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && m_tvalid |-> m_tready)
		else $error("output register overwritten before transfer");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (scan_idx < IDX_W'(WINDOW - 1)) || (scan_idx == IDX_W'(WINDOW - 1)))
		else $error("scan index beyond window");

	a_no_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !s_tready && !cmd.load)
		else $error("scan overlaps idle or result load");

endmodule
